// ===== design/sha_pkg.sv =====
// Package for the SHA-256 byte stream hasher: types, round constants, functions.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } sha_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } sha_out_t;

    typedef logic [31:0] sha_word_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic sha_word_t rotr(input sha_word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic sha_word_t init_h(input logic [2:0] i);
        case (i)
            3'd0: init_h = 32'h6a09e667;
            3'd1: init_h = 32'hbb67ae85;
            3'd2: init_h = 32'h3c6ef372;
            3'd3: init_h = 32'ha54ff53a;
            3'd4: init_h = 32'h510e527f;
            3'd5: init_h = 32'h9b05688c;
            3'd6: init_h = 32'h1f83d9ab;
            default: init_h = 32'h5be0cd19;
        endcase
    endfunction

    localparam sha_word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
endpackage

// ===== design/sha_fifo.sv =====
// Short item queue between the byte front end and the hashing core.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sha_pkg::sha_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output sha_pkg::sha_item_t out_item
);
    import sha_pkg::*;
    localparam int AW = $clog2(DEPTH);

    sha_item_t            mem_reg [DEPTH];
    logic [AW-1:0]        wr_reg, rd_reg;
    logic [AW:0]          cnt_reg;
    logic                 push, pop;

    assign in_ready  = cnt_reg != (AW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count overflow");
    a_nopush_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (AW+1)'(DEPTH)) |-> !push)
        else $error("push into full queue");
    a_nopop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 && !push) |=> cnt_reg == '0 || $past(push))
        else $error("count rose with no push");
endmodule

// ===== design/sha_core.sv =====
// Back end: block collection, padding sequencer, 64-round compression, digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  sha_pkg::sha_item_t item,
    output logic               out_valid,
    input  logic               out_ready,
    output sha_pkg::sha_out_t  out_data
);
    import sha_pkg::*;

    localparam logic [2:0] ST_FILL  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]  state_reg;
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg, total_reg;
    logic        closing_reg, final_reg, msg_end_reg;
    logic [5:0]  round_reg;
    logic [2:0]  emit_reg;
    sha_word_t   blk_reg [16];
    sha_word_t   w_reg [16];
    sha_word_t   h_reg [8];
    sha_word_t   v_reg [8];

    sha_word_t   w_new, s0, s1, t1, t2, ep0, ep1, ch, maj;
    logic [3:0]  wi;
    logic        byte_in;

    assign item_ready = state_reg == ST_FILL;
    assign byte_in = item_valid && item_ready && item.present;
    assign wi = fill_reg[5:2];
    assign out_valid = state_reg == ST_EMIT;
    assign out_data.word  = h_reg[emit_reg];
    assign out_data.index = emit_reg;
    assign out_data.last  = emit_reg == 3'd7;

    always_comb
    begin
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        w_new = (round_reg < 6'd16) ? blk_reg[round_reg[3:0]]
                                    : s1 + w_reg[9] + s0 + w_reg[0];
        ep1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ep0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + ep1 + ch + ROUND_K[round_reg] + w_new;
        t2  = ep0 + maj;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FILL && byte_in)
        begin
            case (fill_reg[1:0])
                2'd0: blk_reg[wi][31:24] <= item.data;
                2'd1: blk_reg[wi][23:16] <= item.data;
                2'd2: blk_reg[wi][15:8]  <= item.data;
                default: blk_reg[wi][7:0] <= item.data;
            endcase
        end
        else if (state_reg == ST_PAD)
        begin
            for (int j = 0; j < 16; j++)
            begin
                if (j == 14 && !closing_reg)
                begin
                    blk_reg[j] <= total_reg[63:32];
                end
                else if (j == 15 && !closing_reg)
                begin
                    blk_reg[j] <= total_reg[31:0];
                end
                else if (4'(j) > wi)
                begin
                    blk_reg[j] <= '0;
                end
            end
            if (!final_reg)
            begin
                case (fill_reg[1:0])
                    2'd0: blk_reg[wi] <= {PAD_BYTE, 24'h0};
                    2'd1: blk_reg[wi] <= {blk_reg[wi][31:24], PAD_BYTE, 16'h0};
                    2'd2: blk_reg[wi] <= {blk_reg[wi][31:16], PAD_BYTE, 8'h0};
                    default: blk_reg[wi] <= {blk_reg[wi][31:8], PAD_BYTE};
                endcase
            end
            else if (closing_reg == 1'b0 && wi < 4'd14)
            begin
                blk_reg[wi] <= '0;
            end
        end
        if (state_reg == ST_ROUND)
        begin
            for (int j = 0; j < 15; j++)
            begin
                w_reg[j] <= w_reg[j+1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else
        begin
            for (int j = 0; j < 8; j++)
            begin
                v_reg[j] <= h_reg[j];
            end
        end
    end

    // final_reg: pad byte already placed in an earlier block (second padding block)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_FILL;
            fill_reg    <= '0;
            bits_reg    <= '0;
            total_reg   <= '0;
            closing_reg <= 1'b0;
            final_reg   <= 1'b0;
            msg_end_reg <= 1'b0;
            round_reg   <= '0;
            emit_reg    <= '0;
            for (int j = 0; j < 8; j++)
            begin
                h_reg[j] <= init_h(3'(j));
            end
        end
        else
        begin
            case (state_reg)
                ST_FILL:
                begin
                    if (item_valid)
                    begin
                        logic [5:0] nf;
                        nf = fill_reg + 6'(item.present);
                        fill_reg <= nf;
                        msg_end_reg <= item.last;
                        if (item.present && nf == 6'd0)
                        begin
                            bits_reg    <= bits_reg + 64'd512;
                            closing_reg <= item.last;
                            final_reg   <= 1'b0;
                            total_reg   <= bits_reg + 64'd512;
                            round_reg   <= '0;
                            state_reg   <= ST_ROUND;
                        end
                        else if (item.last)
                        begin
                            total_reg   <= bits_reg + {55'd0, nf, 3'd0};
                            closing_reg <= nf > 6'd55;
                            final_reg   <= 1'b0;
                            state_reg   <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    round_reg <= '0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int j = 0; j < 8; j++)
                    begin
                        h_reg[j] <= h_reg[j] + v_reg[j];
                    end
                    if (closing_reg)
                    begin
                        // more padding follows; pad byte placed only if block was not full
                        final_reg   <= fill_reg != 6'd0;
                        closing_reg <= 1'b0;
                        fill_reg    <= 6'd0;
                        state_reg   <= ST_PAD;
                    end
                    else if (msg_end_reg)
                    begin
                        emit_reg  <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_FILL;
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7)
                        begin
                            state_reg   <= ST_FILL;
                            fill_reg    <= '0;
                            bits_reg    <= '0;
                            total_reg   <= '0;
                            msg_end_reg <= 1'b0;
                            for (int j = 0; j < 8; j++)
                            begin
                                h_reg[j] <= init_h(3'(j));
                            end
                        end
                    end
                end
                default: state_reg <= ST_FILL;
            endcase
        end
    end

    a_emit_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !item_ready)
        else $error("input taken during digest output");
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> state_reg == ST_ADD)
        else $error("round sequence broken");
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && emit_reg == 3'd7) |=> state_reg == ST_FILL)
        else $error("digest output did not finish");
endmodule

// ===== design/sha256_byte_stream_hasher.sv =====
// SHA-256 byte stream hasher top level: input queue feeding the hashing core.
// Depends on sha_pkg, sha_fifo, sha_core.
//
// Usage: message bytes enter on the s_axis channel, one byte per transfer;
// tuser[0] set means tdata carries a byte, tlast closes the message (a
// transfer with tlast and no byte allows the empty message). After the
// closing transfer the digest leaves on m_axis as eight transfers, word 0
// first; tuser holds the word index and tlast marks word 7.
// Flow: 64 bytes are taken at one per cycle while the queue holds bytes,
// then the core runs the block through its single round unit (one round
// per cycle plus the final add). Closing a message passes the padding
// state before each padding block (two blocks when the length does not
// fit behind the pad byte), then sends the eight output words.
// A four-entry queue keeps accepting bytes, until it is full, while the core compresses.
// Reset returns the chaining value to the initial hash and empties the
// queue. A stall on m_axis holds the current word until it is taken.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);
    import sha_pkg::*;

    sha_item_t in_item, q_item;
    sha_out_t  res;
    logic      q_valid, q_ready;

    assign in_item.data    = s_axis_tdata;
    assign in_item.present = s_axis_tuser;
    assign in_item.last    = s_axis_tlast;

    sha_fifo #(.DEPTH(4)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    sha_core u_core (
        .clk(clk), .rst_n(rst_n),
        .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
    );

    assign m_axis_tdata = res.word;
    assign m_axis_tuser = res.index;
    assign m_axis_tlast = res.last;
endmodule
